FILE: rtl/slx_pkg.sv
// slx_pkg: shared types, constants and helper functions of the source lexer.
// No dependencies; used by the interfaces, the result queue and the top level.
package slx_pkg;

  localparam int unsigned PosBits   = 24;
  localparam int unsigned KwMaxLen  = 9;
  localparam int unsigned KwCntBits = 4;   // holds 0 .. KwMaxLen + 1
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = 2;

  localparam logic [PosBits-1:0] PosMax = '1;
  localparam logic [PosBits-1:0] PosOne = PosBits'(1);

  // Token kinds
  localparam logic [5:0] KindEnd      = 6'd0;
  localparam logic [5:0] KindIdent    = 6'd1;
  localparam logic [5:0] KindNumber   = 6'd2;
  localparam logic [5:0] KindLParen   = 6'd3;
  localparam logic [5:0] KindRParen   = 6'd4;
  localparam logic [5:0] KindLBrace   = 6'd5;
  localparam logic [5:0] KindRBrace   = 6'd6;
  localparam logic [5:0] KindColon    = 6'd7;
  localparam logic [5:0] KindSemi     = 6'd8;
  localparam logic [5:0] KindComma    = 6'd9;
  localparam logic [5:0] KindArrow    = 6'd10;
  localparam logic [5:0] KindAssign   = 6'd11;
  localparam logic [5:0] KindPlus     = 6'd12;
  localparam logic [5:0] KindMinus    = 6'd13;
  localparam logic [5:0] KindStar     = 6'd14;
  localparam logic [5:0] KindSlash    = 6'd15;
  localparam logic [5:0] KindPercent  = 6'd16;
  localparam logic [5:0] KindBang     = 6'd17;
  localparam logic [5:0] KindLess     = 6'd18;
  localparam logic [5:0] KindGreater  = 6'd19;
  localparam logic [5:0] KindLessEq   = 6'd20;
  localparam logic [5:0] KindGreatEq  = 6'd21;
  localparam logic [5:0] KindEqEq     = 6'd22;
  localparam logic [5:0] KindNotEq    = 6'd23;
  localparam logic [5:0] KindAndAnd   = 6'd24;
  localparam logic [5:0] KindOrOr     = 6'd25;
  localparam logic [5:0] KindModule   = 6'd26;
  localparam logic [5:0] KindStruct   = 6'd27;
  localparam logic [5:0] KindInvar    = 6'd28;
  localparam logic [5:0] KindFn       = 6'd29;
  localparam logic [5:0] KindRequires = 6'd30;
  localparam logic [5:0] KindEnsures  = 6'd31;
  localparam logic [5:0] KindLet      = 6'd32;
  localparam logic [5:0] KindAssume   = 6'd33;
  localparam logic [5:0] KindAssert   = 6'd34;
  localparam logic [5:0] KindReturn   = 6'd35;
  localparam logic [5:0] KindTrue     = 6'd36;
  localparam logic [5:0] KindFalse    = 6'd37;

  // Error codes
  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrUnexp = 2'd1;
  localparam logic [1:0] ErrAmp   = 2'd2;
  localparam logic [1:0] ErrBar   = 2'd3;

  // Input operations
  localparam logic OpByte = 1'b0;
  localparam logic OpEnd  = 1'b1;

  typedef enum logic [3:0] {
    ModeIdle, ModeIdent, ModeNumber, ModeSlash, ModeComment, ModeMinus, ModeBang,
    ModeLess, ModeGreater, ModeEqual, ModeAmp, ModeBar, ModeDead
  } scan_mode_e;

  typedef logic [KwMaxLen-1:0][7:0] kw_chars_t;

  typedef struct packed {
    logic [5:0]         kind;
    logic [1:0]         error;
    logic [PosBits-1:0] start_offset;
    logic [PosBits-1:0] length;
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] column;
    logic               last;
  } token_t;

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // Keyword lookup over the held identifier prefix.
  function automatic logic [5:0] kw_kind(input kw_chars_t c,
                                         input logic [KwCntBits-1:0] cnt);
    logic [71:0] s;
    logic [5:0]  k;
    s = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    k = KindIdent;
    case (cnt)
      4'd2: if (s[71 -: 16] == "fn") k = KindFn;
      4'd3: if (s[71 -: 24] == "let") k = KindLet;
      4'd4: if (s[71 -: 32] == "true") k = KindTrue;
      4'd5: if (s[71 -: 40] == "false") k = KindFalse;
      4'd6: begin
        if (s[71 -: 48] == "module") k = KindModule;
        else if (s[71 -: 48] == "struct") k = KindStruct;
        else if (s[71 -: 48] == "assume") k = KindAssume;
        else if (s[71 -: 48] == "assert") k = KindAssert;
        else if (s[71 -: 48] == "return") k = KindReturn;
      end
      4'd7: if (s[71 -: 56] == "ensures") k = KindEnsures;
      4'd8: if (s[71 -: 64] == "requires") k = KindRequires;
      4'd9: if (s == "invariant") k = KindInvar;
      default: k = KindIdent;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/slx_if.sv
// slx_src_if and slx_tok_if: valid/ready channels for source bytes and tokens.
// Depends on slx_pkg for widths.
interface slx_src_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_req;
  modport source (output valid, output op, output byte_req, input ready);
  modport sink   (input valid, input op, input byte_req, output ready);
endinterface

interface slx_tok_if;
  logic                        valid;
  logic                        ready;
  logic [5:0]                  kind;
  logic [1:0]                  error;
  logic [slx_pkg::PosBits-1:0] start_offset;
  logic [slx_pkg::PosBits-1:0] length;
  logic [slx_pkg::PosBits-1:0] line;
  logic [slx_pkg::PosBits-1:0] column;
  logic                        last;
  modport source (output valid, output kind, output error, output start_offset,
                  output length, output line, output column, output last, input ready);
  modport sink   (input valid, input kind, input error, input start_offset,
                  input length, input line, input column, input last, output ready);
endinterface

FILE: rtl/source_lexer_top.sv
// source_lexer_top: streaming lexer, one source byte per transaction in, tokens out.
// Throughput: one byte per cycle; a byte can yield two tokens, and the input stalls
// only while three or more tokens wait in the queue, i.e. while the sink holds back.
// A token is written into the queue when the byte or end marker that completes it is accepted.
// The scanner decides each byte combinationally from its mode register; a 4-entry queue
// holds results. Reset (rst_ni low, async) returns to idle at offset 0, line 1, column 1.
// Depends on slx_pkg, slx_if and slx_queue.
module source_lexer_top (
  input  logic clk_i,
  input  logic rst_ni,
  slx_src_if.sink   src_i,
  slx_tok_if.source tok_o
);
  localparam int unsigned PB = slx_pkg::PosBits;

  slx_pkg::scan_mode_e mode_q, mode_d;
  logic [PB-1:0] pos_q, pos_d, line_q, line_d, col_q, col_d;
  logic [PB-1:0] ts_q, ts_d, tl_q, tl_d, tc_q, tc_d;
  slx_pkg::kw_chars_t kw_q;
  logic [slx_pkg::KwCntBits-1:0] kwc_q, kwc_d;
  logic kw_we;
  logic [3:0] kw_idx;
  logic [7:0] b;
  logic room, accept;
  logic [1:0] n;
  slx_pkg::token_t res [2];
  slx_pkg::token_t head;

  assign src_i.ready = room;
  assign accept = src_i.valid && room;
  assign b = src_i.byte_req;

  function automatic slx_pkg::token_t mk(input logic [5:0] k, input logic [1:0] e,
      input logic [PB-1:0] s, input logic [PB-1:0] l, input logic [PB-1:0] ln,
      input logic [PB-1:0] cl, input logic lst);
    slx_pkg::token_t t;
    t.kind = k; t.error = e; t.start_offset = s; t.length = l;
    t.line = ln; t.column = cl; t.last = lst;
    return t;
  endfunction

  // scanner step for one transaction
  always_comb begin
    logic cont, dead, ws;
    logic [5:0] pair, pend, single;
    logic [7:0] second;
    slx_pkg::scan_mode_e nm;
    mode_d = mode_q; pos_d = pos_q; line_d = line_q; col_d = col_q;
    ts_d = ts_q; tl_d = tl_q; tc_d = tc_q; kwc_d = kwc_q;
    kw_we = 1'b0; kw_idx = kwc_q; n = 2'd0;
    res[0] = '0; res[1] = '0;
    cont = 1'b0; dead = 1'b0; pair = '0; second = '0; single = '0;
    nm = slx_pkg::ModeIdle;
    ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);

    // kind of the token pending in the current mode, zero when none
    case (mode_q)
      slx_pkg::ModeIdent:   pend = slx_pkg::kw_kind(kw_q, kwc_q);
      slx_pkg::ModeNumber:  pend = slx_pkg::KindNumber;
      slx_pkg::ModeSlash:   pend = slx_pkg::KindSlash;
      slx_pkg::ModeMinus:   pend = slx_pkg::KindMinus;
      slx_pkg::ModeBang:    pend = slx_pkg::KindBang;
      slx_pkg::ModeLess:    pend = slx_pkg::KindLess;
      slx_pkg::ModeGreater: pend = slx_pkg::KindGreater;
      slx_pkg::ModeEqual:   pend = slx_pkg::KindAssign;
      default:              pend = '0;
    endcase

    if (src_i.op == slx_pkg::OpEnd) begin
      if (mode_q != slx_pkg::ModeDead) begin
        if (mode_q == slx_pkg::ModeAmp || mode_q == slx_pkg::ModeBar) begin
          res[0] = mk(slx_pkg::KindEnd,
                      (mode_q == slx_pkg::ModeAmp) ? slx_pkg::ErrAmp : slx_pkg::ErrBar,
                      ts_q, slx_pkg::PosOne, tl_q, tc_q, 1'b1);
          n = 2'd1;
        end else begin
          if (pend != '0) begin
            res[0] = mk(pend, slx_pkg::ErrNone, ts_q, pos_q - ts_q, tl_q, tc_q, 1'b0);
            n = 2'd1;
          end
          res[n[0]] = mk(slx_pkg::KindEnd, slx_pkg::ErrNone, pos_q, '0, line_q, col_q, 1'b1);
          n = n + 2'd1;
        end
      end
      mode_d = slx_pkg::ModeIdle;
      pos_d = '0; line_d = slx_pkg::PosOne; col_d = slx_pkg::PosOne;
      ts_d = '0; tl_d = slx_pkg::PosOne; tc_d = slx_pkg::PosOne; kwc_d = '0;
    end else if (mode_q != slx_pkg::ModeDead) begin
      // continuation of the pending token
      case (mode_q)
        slx_pkg::ModeIdent: begin
          if (slx_pkg::is_alpha(b) || slx_pkg::is_digit(b) || b == "_") begin
            cont = 1'b1;
            kw_we = (kwc_q < 4'(slx_pkg::KwMaxLen));
            if (kwc_q <= 4'(slx_pkg::KwMaxLen)) kwc_d = kwc_q + 1'b1;
          end
        end
        slx_pkg::ModeNumber: cont = slx_pkg::is_digit(b);
        slx_pkg::ModeSlash: if (b == "/") begin
          cont = 1'b1; mode_d = slx_pkg::ModeComment;
        end
        slx_pkg::ModeComment: begin
          cont = (b != 8'h0a);
        end
        slx_pkg::ModeMinus:   begin second = ">"; pair = slx_pkg::KindArrow;   end
        slx_pkg::ModeBang:    begin second = "="; pair = slx_pkg::KindNotEq;   end
        slx_pkg::ModeLess:    begin second = "="; pair = slx_pkg::KindLessEq;  end
        slx_pkg::ModeGreater: begin second = "="; pair = slx_pkg::KindGreatEq; end
        slx_pkg::ModeEqual:   begin second = "="; pair = slx_pkg::KindEqEq;    end
        slx_pkg::ModeAmp:     begin second = "&"; pair = slx_pkg::KindAndAnd;  end
        slx_pkg::ModeBar:     begin second = "|"; pair = slx_pkg::KindOrOr;    end
        default: cont = 1'b0;
      endcase

      if (cont) begin
        pos_d = slx_pkg::sat_inc(pos_q);
        if (b == 8'h0a) begin line_d = slx_pkg::sat_inc(line_q); col_d = slx_pkg::PosOne; end
        else col_d = slx_pkg::sat_inc(col_q);
      end else if (pair != '0 && b == second) begin
        pos_d = slx_pkg::sat_inc(pos_q);
        if (b == 8'h0a) begin line_d = slx_pkg::sat_inc(line_q); col_d = slx_pkg::PosOne; end
        else col_d = slx_pkg::sat_inc(col_q);
        res[0] = mk(pair, slx_pkg::ErrNone, ts_q, pos_d - ts_q, tl_q, tc_q, 1'b0);
        n = 2'd1;
        mode_d = slx_pkg::ModeIdle;
      end else begin
        // flush whatever is pending
        if (mode_q == slx_pkg::ModeAmp || mode_q == slx_pkg::ModeBar) begin
          res[0] = mk(slx_pkg::KindEnd,
                      (mode_q == slx_pkg::ModeAmp) ? slx_pkg::ErrAmp : slx_pkg::ErrBar,
                      ts_q, slx_pkg::PosOne, tl_q, tc_q, 1'b1);
          n = 2'd1;
          dead = 1'b1;
          mode_d = slx_pkg::ModeDead;
        end else begin
          if (pend != '0) begin
            res[0] = mk(pend, slx_pkg::ErrNone, ts_q, pos_q - ts_q, tl_q, tc_q, 1'b0);
            n = 2'd1;
          end
          mode_d = slx_pkg::ModeIdle;
        end

        if (!dead) begin
          if (ws) begin
            pos_d = slx_pkg::sat_inc(pos_q);
            if (b == 8'h0a) begin
              line_d = slx_pkg::sat_inc(line_q); col_d = slx_pkg::PosOne;
            end
            else col_d = slx_pkg::sat_inc(col_q);
          end else begin
            ts_d = pos_q; tl_d = line_q; tc_d = col_q;
            case (b)
              "(": single = slx_pkg::KindLParen;
              ")": single = slx_pkg::KindRParen;
              "{": single = slx_pkg::KindLBrace;
              "}": single = slx_pkg::KindRBrace;
              ":": single = slx_pkg::KindColon;
              ";": single = slx_pkg::KindSemi;
              ",": single = slx_pkg::KindComma;
              "+": single = slx_pkg::KindPlus;
              "*": single = slx_pkg::KindStar;
              "%": single = slx_pkg::KindPercent;
              "/": nm = slx_pkg::ModeSlash;
              "-": nm = slx_pkg::ModeMinus;
              "!": nm = slx_pkg::ModeBang;
              "<": nm = slx_pkg::ModeLess;
              ">": nm = slx_pkg::ModeGreater;
              "=": nm = slx_pkg::ModeEqual;
              "&": nm = slx_pkg::ModeAmp;
              "|": nm = slx_pkg::ModeBar;
              default: nm = slx_pkg::ModeIdle;
            endcase
            if (slx_pkg::is_alpha(b) || b == "_") begin
              nm = slx_pkg::ModeIdent;
              kw_we = 1'b1; kw_idx = '0; kwc_d = 4'd1;
            end else if (slx_pkg::is_digit(b)) begin
              nm = slx_pkg::ModeNumber;
            end
            if (single == '0 && nm == slx_pkg::ModeIdle) begin
              // unexpected byte: error at this byte, source closed
              res[n[0]] = mk(slx_pkg::KindEnd, slx_pkg::ErrUnexp, pos_q, slx_pkg::PosOne,
                             line_q, col_q, 1'b1);
              n = n + 2'd1;
              mode_d = slx_pkg::ModeDead;
            end else begin
              pos_d = slx_pkg::sat_inc(pos_q);
              col_d = slx_pkg::sat_inc(col_q);
              if (single != '0) begin
                res[n[0]] = mk(single, slx_pkg::ErrNone, pos_q, pos_d - pos_q,
                               line_q, col_q, 1'b0);
                n = n + 2'd1;
              end else begin
                mode_d = nm;
              end
            end
          end
        end
      end
    end
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= slx_pkg::ModeIdle;
      pos_q  <= '0;
      line_q <= slx_pkg::PosOne;
      col_q  <= slx_pkg::PosOne;
      ts_q   <= '0;
      tl_q   <= slx_pkg::PosOne;
      tc_q   <= slx_pkg::PosOne;
      kwc_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      line_q <= line_d;
      col_q  <= col_d;
      ts_q   <= ts_d;
      tl_q   <= tl_d;
      tc_q   <= tc_d;
      kwc_q  <= kwc_d;
    end
  end

  // identifier characters, only read back up to the held count
  always_ff @(posedge clk_i) begin
    if (accept && kw_we) kw_q[kw_idx] <= b;
  end

  slx_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (accept ? n : 2'd0),
    .push0_i    (res[0]),
    .push1_i    (res[1]),
    .room_o     (room),
    .valid_o    (tok_o.valid),
    .pop_i      (tok_o.ready),
    .head_o     (head)
  );

  assign tok_o.kind         = head.kind;
  assign tok_o.error        = head.error;
  assign tok_o.start_offset = head.start_offset;
  assign tok_o.length       = head.length;
  assign tok_o.line         = head.line;
  assign tok_o.column       = head.column;
  assign tok_o.last         = head.last;
endmodule

FILE: rtl/slx_queue.sv
// slx_queue: small token queue taking up to two pushes per cycle, one pop.
// Depends on slx_pkg (token_t, queue sizing).
module slx_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  slx_pkg::token_t push0_i,
  input  slx_pkg::token_t push1_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            pop_i,
  output slx_pkg::token_t head_o
);
  slx_pkg::token_t mem_q [slx_pkg::QueueDepth];
  logic [slx_pkg::QueuePtrBits-1:0] wr_q, rd_q;
  logic [slx_pkg::QueuePtrBits:0]   cnt_q;
  logic do_pop;
  logic [slx_pkg::QueuePtrBits-1:0] wr1;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;
  // two free slots needed before accepting a transaction
  assign room_o  = (cnt_q <= (slx_pkg::QueuePtrBits+1)'(slx_pkg::QueueDepth - 2));
  assign wr1     = wr_q + 1'b1;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr1]  <= push1_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + slx_pkg::QueuePtrBits'(push_cnt_i);
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (slx_pkg::QueuePtrBits+1)'(push_cnt_i)
                     - (slx_pkg::QueuePtrBits+1)'(do_pop);
    end
  end
endmodule
